>>> hdl/apev2_tag_stream_parser_unit_defines.svh
// Assertion macros shared by the parser modules.
`ifndef APEV2_TAG_STREAM_PARSER_UNIT_DEFINES_SVH
`define APEV2_TAG_STREAM_PARSER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checks that a condition implies a consequence in the same cycle.
`define APE_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define APE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define APE_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg)
`define APE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

>>> hdl/apev2_pkg.sv
`default_nettype none
package apev2_pkg;

    localparam logic [63:0] MAGIC_WORD = 64'h5845_4741_5445_5041;
    localparam logic [31:0] HDR_MASK_RESET = 32'h2000_0000;

    typedef enum logic [2:0] {
        EV_HEADER = 3'd0,
        EV_ITEM   = 3'd1,
        EV_FOOTER = 3'd2,
        EV_ERROR  = 3'd3,
        EV_FINISH = 3'd4
    } t_kind;

    localparam logic [2:0] ERR_HEAD_SHORT = 3'd0;
    localparam logic [2:0] ERR_FOOT_ONLY  = 3'd1;
    localparam logic [2:0] ERR_TAG_SHORT  = 3'd2;
    localparam logic [2:0] ERR_ITEM_HEAD  = 3'd3;
    localparam logic [2:0] ERR_KEY        = 3'd4;
    localparam logic [2:0] ERR_VALUE      = 3'd5;
    localparam logic [2:0] FIN_OK         = 3'd0;
    localparam logic [2:0] FIN_INVALID    = 3'd1;
    localparam logic [2:0] FIN_BAD_MAGIC  = 3'd2;

    // One result event.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] offset;
        logic [31:0] version;
        logic [31:0] size;
        logic [31:0] count;
        logic [31:0] flags;
        logic [31:0] klen;
        logic [2:0]  code;
        logic        last;
    } t_event;

    // Up to three events caused by one byte.
    typedef struct packed {
        logic [1:0] num;
        t_event     ev0;
        t_event     ev1;
        t_event     ev2;
    } t_group;

endpackage
`default_nettype wire

>>> hdl/apev2_tag_stream_parser_unit.sv
// Events: the events of an accepted byte are written into the event queue and
// sent from it one by one. Throughput: one byte per cycle while the queue is
// not full; the four-group event queue absorbs bytes causing up to three events.
// Reset: synchronous active low; clears the parse and the queue and loads the
// header flag mask with 0x20000000. A last byte rearms the parse, mask kept.
`default_nettype none
module apev2_tag_stream_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte [7:0], source_length [39:8]
    input  wire  [39:0] s_axis_tdata,
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // event_kind [2:0], offset [34:3], version [66:35], size_or_value_length
    // [98:67], item_count [130:99], flags [162:131], key_length [194:163],
    // code [197:195], zero fill [199:198]
    output logic [199:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    logic push, full, empty, pop;
    apev2_pkg::t_group g_in, g_out;
    apev2_pkg::t_event ev;

    apev2_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_byte(s_axis_tdata[7:0]),
        .i_src_len(s_axis_tdata[39:8]), .i_last(s_axis_tlast), .o_push(push),
        .o_group(g_in), .i_full(full)
    );

    apev2_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_group(g_in),
        .o_full(full), .o_empty(empty), .o_group(g_out), .i_pop(pop)
    );

    apev2_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_group(g_out),
        .o_pop(pop), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_event(ev)
    );

    // Output packing.
    assign m_axis_tdata = {2'b00, ev.code, ev.klen, ev.flags, ev.count, ev.size,
                           ev.version, ev.offset, ev.kind};
    assign m_axis_tlast = ev.last;

endmodule
`default_nettype wire

>>> hdl/apev2_front.sv
`default_nettype none
`include "apev2_tag_stream_parser_unit_defines.svh"
// Front part: takes one byte per cycle while the queue is not full, tracks the parse and forms event groups.
module apev2_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [31:0]       i_cfg_data,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [7:0]        i_byte,
    input  wire  [31:0]       i_src_len,
    input  wire               i_last,
    output logic              o_push,
    output apev2_pkg::t_group o_group,
    input  wire               i_full
);

    typedef enum logic [6:0] {
        PH_MAGIC    = 7'b0000001,
        PH_HEAD     = 7'b0000010,
        PH_ITEMHEAD = 7'b0000100,
        PH_KEY      = 7'b0001000,
        PH_VALUE    = 7'b0010000,
        PH_FOOT     = 7'b0100000,
        PH_DONE     = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, r_blen, n_blen, r_istart, n_istart;
    logic [32:0] r_tend, n_tend;
    logic [63:0] r_head, n_head;
    logic [31:0] r_ws [4];
    logic [31:0] n_ws [4];
    logic [31:0] r_kcnt, n_kcnt, r_vrem, n_vrem, r_mask;
    logic [31:0] rel;
    logic [32:0] pos1;
    logic [32:0] vsum;
    logic        fire;
    apev2_pkg::t_group grp;

    assign o_ready = !i_full;
    assign fire    = i_valid && o_ready;
    assign rel     = r_pos - r_istart;
    assign pos1    = {1'b0, r_pos} + 33'd1;
    assign vsum    = pos1 + {1'b0, r_ws[0]};

    function automatic apev2_pkg::t_event mk(apev2_pkg::t_kind k, logic [31:0] off,
                                             logic [31:0] ver, logic [31:0] sz,
                                             logic [31:0] cnt, logic [31:0] flg,
                                             logic [31:0] kl, logic [2:0] cd);
        apev2_pkg::t_event e;
        e.kind = k; e.offset = off; e.version = ver; e.size = sz; e.count = cnt;
        e.flags = flg; e.klen = kl; e.code = cd; e.last = 1'b0;
        return e;
    endfunction

    // Per-byte parse step.
    always_comb begin
        logic [2:0] fcode;
        logic       fin, done;
        logic [32:0] st;
        logic       bi;
        fcode = apev2_pkg::FIN_OK; fin = 1'b0; done = 1'b0; bi = 1'b0; st = '0;
        grp = '0;
        n_phase = r_phase; n_blen = r_blen; n_istart = r_istart; n_tend = r_tend;
        n_kcnt = r_kcnt; n_vrem = r_vrem;
        for (int i = 0; i < 4; i++) n_ws[i] = r_ws[i];
        n_head = {i_byte, r_head[63:8]};

        unique case (r_phase)
            PH_MAGIC: begin
                if (r_pos == 32'd0) n_blen = i_src_len;
                if (n_blen < 32'd8) begin
                    fin = 1'b1; fcode = apev2_pkg::FIN_BAD_MAGIC;
                end else if (r_pos == 32'd7) begin
                    if (n_head != apev2_pkg::MAGIC_WORD) begin
                        fin = 1'b1; fcode = apev2_pkg::FIN_BAD_MAGIC;
                    end else if (n_blen < 32'd32) begin
                        grp.ev0 = mk(apev2_pkg::EV_ERROR, '0, '0, '0, '0, '0, '0,
                                     apev2_pkg::ERR_HEAD_SHORT);
                        grp.num = 2'd1; fin = 1'b1; fcode = apev2_pkg::FIN_INVALID;
                    end else begin
                        n_phase = PH_HEAD;
                    end
                end
            end
            PH_HEAD: begin
                if (r_pos == 32'd11) n_ws[0] = n_head[63:32];
                if (r_pos == 32'd15) n_ws[1] = n_head[63:32];
                if (r_pos == 32'd19) n_ws[2] = n_head[63:32];
                if (r_pos == 32'd23) n_ws[3] = n_head[63:32];
                if (r_pos == 32'd31) begin
                    grp.ev0 = mk(apev2_pkg::EV_HEADER, '0, r_ws[0], r_ws[1], r_ws[2],
                                 r_ws[3], '0, '0);
                    grp.num = 2'd1;
                    if ((r_ws[3] & r_mask) == 32'd0) begin
                        grp.ev1 = mk(apev2_pkg::EV_ERROR, '0, '0, '0, '0, '0, '0,
                                     apev2_pkg::ERR_FOOT_ONLY);
                        grp.num = 2'd2; fin = 1'b1; fcode = apev2_pkg::FIN_INVALID;
                    end else begin
                        n_tend = 33'd32 + {1'b0, r_ws[1]};
                        if (n_tend > {1'b0, r_blen}) begin
                            grp.ev1 = mk(apev2_pkg::EV_ERROR, '0, '0, '0, '0, '0, '0,
                                         apev2_pkg::ERR_TAG_SHORT);
                            grp.num = 2'd2; fin = 1'b1;
                            fcode = apev2_pkg::FIN_INVALID;
                        end else begin
                            bi = 1'b1; st = 33'd32;
                        end
                    end
                end
            end
            PH_ITEMHEAD: begin
                if (rel == 32'd3) n_ws[0] = n_head[63:32];
                if (rel == 32'd7) begin
                    n_ws[1] = n_head[63:32];
                    if (n_head == apev2_pkg::MAGIC_WORD &&
                        ({1'b0, r_istart} + 33'd32) == r_tend) begin
                        n_phase = PH_FOOT;
                    end else begin
                        n_kcnt = '0;
                        if (({1'b0, r_istart} + 33'd8) >= r_tend) begin
                            grp.ev0 = mk(apev2_pkg::EV_ERROR, r_istart, '0, '0, '0, '0,
                                         '0, apev2_pkg::ERR_KEY);
                            grp.num = 2'd1; fin = 1'b1;
                        end else begin
                            n_phase = PH_KEY;
                        end
                    end
                end
            end
            PH_KEY: begin
                if (i_byte == 8'd0) begin
                    if ({1'b0, vsum} > {1'b0, r_tend}) begin
                        grp.ev0 = mk(apev2_pkg::EV_ERROR, r_istart, '0, '0, '0, '0, '0,
                                     apev2_pkg::ERR_VALUE);
                        grp.num = 2'd1; fin = 1'b1;
                    end else if (r_ws[0] == 32'd0) begin
                        grp.ev0 = mk(apev2_pkg::EV_ITEM, r_istart, '0, r_ws[0], '0,
                                     r_ws[1], r_kcnt, '0);
                        grp.num = 2'd1; bi = 1'b1; st = pos1;
                    end else begin
                        n_vrem = r_ws[0]; n_phase = PH_VALUE;
                    end
                end else begin
                    n_kcnt = r_kcnt + 32'd1;
                    if (pos1 >= r_tend) begin
                        grp.ev0 = mk(apev2_pkg::EV_ERROR, r_istart, '0, '0, '0, '0, '0,
                                     apev2_pkg::ERR_KEY);
                        grp.num = 2'd1; fin = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                n_vrem = r_vrem - 32'd1;
                if (n_vrem == 32'd0) begin
                    grp.ev0 = mk(apev2_pkg::EV_ITEM, r_istart, '0, r_ws[0], '0, r_ws[1],
                                 r_kcnt, '0);
                    grp.num = 2'd1; bi = 1'b1; st = pos1;
                end
            end
            PH_FOOT: begin
                if (rel == 32'd11) n_ws[0] = n_head[63:32];
                if (rel == 32'd15) n_ws[1] = n_head[63:32];
                if (rel == 32'd19) n_ws[2] = n_head[63:32];
                if (rel == 32'd23) begin
                    n_ws[3] = n_head[63:32];
                    grp.ev0 = mk(apev2_pkg::EV_FOOTER, r_istart, r_ws[0], r_ws[1],
                                 r_ws[2], n_head[63:32], '0, '0);
                    grp.num = 2'd1; fin = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // Start of the next item, or the end of the tag.
        if (bi) begin
            if (st == r_tend && r_phase != PH_HEAD || st == n_tend && r_phase == PH_HEAD) begin
                fin = 1'b1;
            end else begin
                n_istart = st[31:0];
                if ((st + 33'd8) > n_tend) begin
                    if (grp.num == 2'd0) begin
                        grp.ev0 = mk(apev2_pkg::EV_ERROR, st[31:0], '0, '0, '0, '0, '0,
                                     apev2_pkg::ERR_ITEM_HEAD);
                    end else begin
                        grp.ev1 = mk(apev2_pkg::EV_ERROR, st[31:0], '0, '0, '0, '0, '0,
                                     apev2_pkg::ERR_ITEM_HEAD);
                    end
                    grp.num = grp.num + 2'd1; fin = 1'b1;
                end else begin
                    n_phase = PH_ITEMHEAD;
                end
            end
        end

        done = fin || (r_phase == PH_DONE);
        if (!fin && i_last && !done) begin
            fin = 1'b1; fcode = apev2_pkg::FIN_INVALID;
        end
        if (fin) begin
            n_phase = PH_DONE;
            unique case (grp.num)
                2'd0: grp.ev0 = mk(apev2_pkg::EV_FINISH, '0, '0, '0, '0, '0, '0, fcode);
                2'd1: grp.ev1 = mk(apev2_pkg::EV_FINISH, '0, '0, '0, '0, '0, '0, fcode);
                default: grp.ev2 = mk(apev2_pkg::EV_FINISH, '0, '0, '0, '0, '0, '0, fcode);
            endcase
            grp.num = grp.num + 2'd1;
        end
        unique case (grp.num)
            2'd1: grp.ev0.last = 1'b1;
            2'd2: grp.ev1.last = 1'b1;
            2'd3: grp.ev2.last = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_push  = fire && (grp.num != 2'd0);
    assign o_group = grp;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= apev2_pkg::HDR_MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_data;
        end
    end

    // Parse state; the last byte rearms everything but the register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_last)) begin
            r_phase <= PH_MAGIC; r_pos <= '0; r_blen <= '0; r_tend <= '0;
            r_istart <= '0; r_head <= '0; r_kcnt <= '0; r_vrem <= '0;
            for (int i = 0; i < 4; i++) r_ws[i] <= '0;
        end else if (fire) begin
            r_phase <= n_phase; r_pos <= r_pos + 32'd1; r_blen <= n_blen;
            r_tend <= n_tend; r_istart <= n_istart; r_head <= n_head;
            r_kcnt <= n_kcnt; r_vrem <= n_vrem;
            for (int i = 0; i < 4; i++) r_ws[i] <= n_ws[i];
        end
    end

    `APE_ASSERT_IMPL(a_push_has_last, i_clk, i_rst_n, o_push,
        (grp.num == 2'd1 && grp.ev0.last) || (grp.num == 2'd2 && grp.ev1.last) ||
        (grp.num == 2'd3 && grp.ev2.last), "event group without last marker")
    `APE_ASSERT_NEXT(a_last_rearms, i_clk, i_rst_n, fire && i_last,
        r_phase == PH_MAGIC && r_pos == 32'd0, "parser did not rearm")
    `APE_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, o_push, !i_full,
        "push into a full queue")

endmodule
`default_nettype wire

>>> hdl/apev2_queue.sv
`default_nettype none
`include "apev2_tag_stream_parser_unit_defines.svh"
// Short queue of event groups between front and back.
module apev2_queue #(
    parameter int DEPTH = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire apev2_pkg::t_group i_group,
    output logic              o_full,
    output logic              o_empty,
    output apev2_pkg::t_group o_group,
    input  wire               i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    apev2_pkg::t_group r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_group = r_mem[r_rp];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_group;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    `APE_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "queue overflow")
    `APE_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue underflow")
    `APE_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1,
        r_cnt <= (AW+1)'(DEPTH), "fill count out of range")

endmodule
`default_nettype wire

>>> hdl/apev2_back.sv
`default_nettype none
`include "apev2_tag_stream_parser_unit_defines.svh"
// Back part: sends the events of each group one by one on the output stream.
module apev2_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_empty,
    input  wire apev2_pkg::t_group i_group,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_ready,
    output apev2_pkg::t_event o_event
);
    logic [1:0] r_idx;

    assign o_valid = !i_empty;
    always_comb begin
        unique case (r_idx)
            2'd0: o_event = i_group.ev0;
            2'd1: o_event = i_group.ev1;
            default: o_event = i_group.ev2;
        endcase
    end
    assign o_pop = o_valid && i_ready && (r_idx + 2'd1 == i_group.num);

    // Event index within the head group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_idx <= o_pop ? 2'd0 : r_idx + 2'd1;
        end
    end

    `APE_ASSERT_IMPL(a_idx_in_group, i_clk, i_rst_n, o_valid, r_idx < i_group.num,
        "event index beyond group")
    `APE_ASSERT_IMPL(a_pop_last, i_clk, i_rst_n, o_pop, o_event.last,
        "group popped before its last event")
    `APE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid,
        "event dropped while stalled")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    // One parser event as seen on the output stream.
    typedef struct {
        apev2_pkg::t_kind kind;
        logic [31:0] offset;
        logic [31:0] version;
        logic [31:0] size;
        logic [31:0] count;
        logic [31:0] flags;
        logic [31:0] klen;
        logic [2:0]  code;
        logic        last;
    } t_tag_event;

    // One byte offered to the parser.
    typedef struct {
        logic [7:0]  data;
        logic [31:0] src_len;
        logic        last;
    } t_tag_byte;

    typedef enum logic [6:0] {
        PH_MAGIC    = 7'b0000001,
        PH_HEAD     = 7'b0000010,
        PH_ITEMHEAD = 7'b0000100,
        PH_KEY      = 7'b0001000,
        PH_VALUE    = 7'b0010000,
        PH_FOOT     = 7'b0100000,
        PH_DONE     = 7'b1000000
    } t_phase;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [199:0] m_axis_tdata;
    wire          m_axis_tlast;

    apev2_tag_stream_parser_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state of the parser.
    logic [31:0] hdr_mask;
    t_phase      ph;
    logic [31:0] pos_cnt;
    logic [31:0] buf_len;
    logic [32:0] tag_end;
    logic [31:0] item_start;
    logic [63:0] head_sr;
    logic [31:0] words [4];
    logic [31:0] key_cnt;
    logic [31:0] val_left;

    t_tag_event  event_q [$];
    t_tag_byte   byte_q [$];
    int          err_cnt = 0;
    int          byte_cnt = 0;
    bit          stall_rx = 1'b0;
    bit          idle_ok = 1'b1;
    bit          hold_tx = 1'b0;
    t_tag_event  step_ev [$];

    task automatic clear_parse();
        ph = PH_MAGIC;
        pos_cnt = '0;
        buf_len = '0;
        tag_end = '0;
        item_start = '0;
        head_sr = '0;
        for (int i = 0; i < 4; i++) words[i] = '0;
        key_cnt = '0;
        val_left = '0;
    endtask

    function automatic void push_event(apev2_pkg::t_kind k, logic [31:0] off,
                                       logic [31:0] ver, logic [31:0] sz,
                                       logic [31:0] cnt, logic [31:0] flg,
                                       logic [31:0] kl, logic [2:0] cd);
        t_tag_event e;
        if (step_ev.size() >= 3) return;
        e.kind = k; e.offset = off; e.version = ver; e.size = sz; e.count = cnt;
        e.flags = flg; e.klen = kl; e.code = cd; e.last = 1'b0;
        step_ev.push_back(e);
    endfunction

    function automatic void tag_finish(logic [2:0] cd);
        push_event(apev2_pkg::EV_FINISH, '0, '0, '0, '0, '0, '0, cd);
        ph = PH_DONE;
    endfunction

    function automatic void item_fail(logic [2:0] cd);
        push_event(apev2_pkg::EV_ERROR, item_start, '0, '0, '0, '0, '0, cd);
        tag_finish(apev2_pkg::FIN_OK);
    endfunction

    function automatic void open_item(logic [32:0] start);
        if (start == tag_end) begin
            tag_finish(apev2_pkg::FIN_OK);
            return;
        end
        item_start = start[31:0];
        if ({1'b0, start} + 34'd8 > {1'b0, tag_end}) begin
            item_fail(apev2_pkg::ERR_ITEM_HEAD);
            return;
        end
        ph = PH_ITEMHEAD;
    endfunction

    // Advance the parser model by one accepted byte and queue its events.
    task automatic parse_byte(t_tag_byte tb);
        logic [32:0] pos;
        logic [31:0] rel;
        logic [33:0] vend;
        pos = {1'b0, pos_cnt};
        rel = pos_cnt - item_start;
        step_ev.delete();
        head_sr = {tb.data, head_sr[63:8]};
        case (ph)
            PH_MAGIC: begin
                if (pos == 0) buf_len = tb.src_len;
                if (buf_len < 8) begin
                    tag_finish(apev2_pkg::FIN_BAD_MAGIC);
                end else if (pos == 7) begin
                    if (head_sr != apev2_pkg::MAGIC_WORD) begin
                        tag_finish(apev2_pkg::FIN_BAD_MAGIC);
                    end else if (buf_len < 32) begin
                        push_event(apev2_pkg::EV_ERROR, '0, '0, '0, '0, '0, '0,
                                   apev2_pkg::ERR_HEAD_SHORT);
                        tag_finish(apev2_pkg::FIN_INVALID);
                    end else ph = PH_HEAD;
                end
            end
            PH_HEAD: begin
                if (pos == 11 || pos == 15 || pos == 19 || pos == 23)
                    words[2'((pos - 33'd11) >> 2)] = head_sr[63:32];
                if (pos == 31) begin
                    push_event(apev2_pkg::EV_HEADER, '0, words[0], words[1], words[2],
                               words[3], '0, '0);
                    if ((words[3] & hdr_mask) == 0) begin
                        push_event(apev2_pkg::EV_ERROR, '0, '0, '0, '0, '0, '0,
                                   apev2_pkg::ERR_FOOT_ONLY);
                        tag_finish(apev2_pkg::FIN_INVALID);
                    end else begin
                        tag_end = 33'd32 + {1'b0, words[1]};
                        if (tag_end > {1'b0, buf_len}) begin
                            push_event(apev2_pkg::EV_ERROR, '0, '0, '0, '0, '0, '0,
                                       apev2_pkg::ERR_TAG_SHORT);
                            tag_finish(apev2_pkg::FIN_INVALID);
                        end else open_item(33'd32);
                    end
                end
            end
            PH_ITEMHEAD: begin
                if (rel == 3) words[0] = head_sr[63:32];
                if (rel == 7) begin
                    words[1] = head_sr[63:32];
                    if (head_sr == apev2_pkg::MAGIC_WORD &&
                        {1'b0, item_start} + 33'd32 == tag_end)
                        ph = PH_FOOT;
                    else begin
                        key_cnt = '0;
                        if ({1'b0, item_start} + 33'd8 >= tag_end)
                            item_fail(apev2_pkg::ERR_KEY);
                        else ph = PH_KEY;
                    end
                end
            end
            PH_KEY: begin
                if (tb.data == 0) begin
                    vend = {1'b0, pos} + 34'd1 + {2'b00, words[0]};
                    if (vend > {1'b0, tag_end}) item_fail(apev2_pkg::ERR_VALUE);
                    else if (words[0] == 0) begin
                        push_event(apev2_pkg::EV_ITEM, item_start, '0, words[0], '0,
                                   words[1], key_cnt, '0);
                        open_item(pos + 33'd1);
                    end else begin
                        val_left = words[0];
                        ph = PH_VALUE;
                    end
                end else begin
                    key_cnt++;
                    if (pos + 33'd1 >= tag_end) item_fail(apev2_pkg::ERR_KEY);
                end
            end
            PH_VALUE: begin
                val_left--;
                if (val_left == 0) begin
                    push_event(apev2_pkg::EV_ITEM, item_start, '0, words[0], '0,
                               words[1], key_cnt, '0);
                    open_item(pos + 33'd1);
                end
            end
            PH_FOOT: begin
                if (rel == 11 || rel == 15 || rel == 19 || rel == 23)
                    words[2'((rel - 32'd11) >> 2)] = head_sr[63:32];
                if (rel == 23) begin
                    push_event(apev2_pkg::EV_FOOTER, item_start, words[0], words[1],
                               words[2], words[3], '0, '0);
                    tag_finish(apev2_pkg::FIN_OK);
                end
            end
            default: ;
        endcase
        pos_cnt++;
        if (tb.last) begin
            if (ph != PH_DONE) tag_finish(apev2_pkg::FIN_INVALID);
            clear_parse();
        end
        if (step_ev.size() > 0) step_ev[step_ev.size() - 1].last = 1'b1;
        foreach (step_ev[i]) event_q.push_back(step_ev[i]);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
        err_cnt++;
    endtask

    // Driver: offers bytes from the pending queue and updates the model on acceptance.
    always @(posedge i_clk) begin
        t_tag_byte nb;
        if (s_axis_tvalid && s_axis_tready) begin
            nb.data = s_axis_tdata[7:0];
            nb.src_len = s_axis_tdata[39:8];
            nb.last = s_axis_tlast;
            parse_byte(nb);
            byte_cnt++;
            void'(byte_q.pop_front());
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            s_axis_tvalid <= 1'b1;
        end else if (hold_tx || byte_q.size() == 0 ||
                     (idle_ok && $urandom_range(99) < 20)) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {byte_q[0].src_len, byte_q[0].data};
            s_axis_tlast <= byte_q[0].last;
        end
    end

    // Monitor: compares each accepted event with the oldest prediction.
    always @(posedge i_clk) begin
        t_tag_event w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (event_q.size() == 0) begin
                report_mismatch("unexpected event kind", 32'(m_axis_tdata[2:0]), '0);
            end else begin
                w = event_q.pop_front();
                if (m_axis_tdata[2:0] != w.kind)
                    report_mismatch("kind", 32'(m_axis_tdata[2:0]), 32'(w.kind));
                if (m_axis_tdata[34:3] != w.offset)
                    report_mismatch("offset", m_axis_tdata[34:3], w.offset);
                if (m_axis_tdata[66:35] != w.version)
                    report_mismatch("version", m_axis_tdata[66:35], w.version);
                if (m_axis_tdata[98:67] != w.size)
                    report_mismatch("size", m_axis_tdata[98:67], w.size);
                if (m_axis_tdata[130:99] != w.count)
                    report_mismatch("count", m_axis_tdata[130:99], w.count);
                if (m_axis_tdata[162:131] != w.flags)
                    report_mismatch("flags", m_axis_tdata[162:131], w.flags);
                if (m_axis_tdata[194:163] != w.klen)
                    report_mismatch("klen", m_axis_tdata[194:163], w.klen);
                if (m_axis_tdata[197:195] != w.code)
                    report_mismatch("code", 32'(m_axis_tdata[197:195]), 32'(w.code));
                if (m_axis_tlast != w.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(w.last));
            end
        end
        m_axis_tready <= !stall_rx && !(idle_ok && $urandom_range(99) < 20);
    end

    // Long receiver hold-off, counted in cycles.
    initial begin
        wait (byte_cnt >= 150);
        stall_rx = 1'b1;
        repeat (60) @(posedge i_clk);
        stall_rx = 1'b0;
    end

    task automatic add_byte(logic [7:0] d, logic [31:0] len, logic l);
        t_tag_byte b;
        b.data = d; b.src_len = len; b.last = l;
        byte_q.push_back(b);
    endtask

    task automatic add_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8], $urandom, 1'b0);
    endtask

    task automatic add_magic(logic [31:0] len);
        logic [63:0] m;
        m = apev2_pkg::MAGIC_WORD;
        add_byte(m[7:0], len, 1'b0);
        for (int i = 1; i < 8; i++) add_byte(m[8*i +: 8], $urandom, 1'b0);
    endtask

    // Builds one tag buffer: header, random items, optional footer, optional damage.
    task automatic add_tag(logic [31:0] flag_word, int n_items, bit footer, int damage);
        int klen [8];
        int vlen [8];
        int body;
        int tsize;
        int total;
        int sent;
        int cut;
        body = 0;
        for (int i = 0; i < n_items; i++) begin
            klen[i] = $urandom_range(0, 4);
            vlen[i] = $urandom_range(0, 4);
            body += 8 + klen[i] + 1 + vlen[i];
        end
        tsize = body + (footer ? 32 : 0);
        if (damage == 1) tsize += $urandom_range(1, 3);
        total = 32 + tsize + $urandom_range(0, 2);
        if (damage == 2) tsize = total - 32 + $urandom_range(1, 40);
        cut = (damage == 3) ? $urandom_range(1, total - 1) : total;
        add_magic(total);
        add_word($urandom);
        add_word(tsize);
        add_word($urandom);
        add_word(flag_word);
        add_word($urandom);
        add_word($urandom);
        for (int i = 0; i < n_items; i++) begin
            add_word((damage == 4 && i == n_items - 1) ? vlen[i] + 50 : vlen[i]);
            add_word($urandom);
            for (int k = 0; k < klen[i]; k++)
                add_byte(8'($urandom_range(1, 255)), $urandom, 1'b0);
            add_byte(8'h00, $urandom, 1'b0);
            for (int k = 0; k < vlen[i]; k++) add_byte(8'($urandom), $urandom, 1'b0);
        end
        if (footer) begin
            add_magic($urandom);
            add_word($urandom);
            add_word(tsize);
            add_word($urandom);
            add_word($urandom);
            add_word($urandom);
            add_word($urandom);
        end
        sent = byte_q.size();
        while (byte_q.size() - sent + (32 + tsize) < total && damage != 2)
            add_byte(8'($urandom), $urandom, 1'b0);
        byte_q[byte_q.size() - 1].last = 1'b1;
        if (damage == 3) begin
            while (byte_q.size() > sent - (32 + tsize) + cut && byte_q.size() > 1)
                void'(byte_q.pop_back());
            byte_q[byte_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic wait_drained();
        wait (byte_q.size() == 0 && !s_axis_tvalid && event_q.size() == 0);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [31:0] m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hdr_mask = m;
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) add_byte(8'($urandom), $urandom, i == n - 1);
    endtask

    initial begin
        hdr_mask = apev2_pkg::HDR_MASK_RESET;
        clear_parse();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short buffers, bad magic, header errors, item errors, footer.
        add_byte(8'h41, 32'd7, 1'b1);
        add_byte(8'hFF, 32'hFFFF_FFFF, 1'b0);
        add_byte(8'h00, 32'd1, 1'b1);
        add_magic(31);
        byte_q[byte_q.size() - 1].last = 1'b1;
        add_magic(8);
        byte_q[byte_q.size() - 1].last = 1'b1;
        add_tag(32'h0000_0000, 0, 0, 0);
        add_tag(32'hFFFF_FFFF, 1, 1, 0);
        add_tag(apev2_pkg::HDR_MASK_RESET, 0, 0, 0);
        add_tag(apev2_pkg::HDR_MASK_RESET, 1, 0, 1);
        add_tag(apev2_pkg::HDR_MASK_RESET, 1, 0, 2);
        add_tag(apev2_pkg::HDR_MASK_RESET, 2, 1, 3);
        add_tag(apev2_pkg::HDR_MASK_RESET, 1, 0, 4);
        wait_drained();

        // Random phases under several mask settings.
        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: write_mask(32'h0000_0000);
                1: write_mask(32'hFFFF_FFFF);
                default: write_mask($urandom | 32'h1);
            endcase
            idle_ok = (phase_no != 2);
            if ($urandom_range(9) < 8)
                add_tag(($urandom_range(3) == 0) ? $urandom : hdr_mask | $urandom,
                        $urandom_range(0, 2), 1'($urandom_range(1)),
                        ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
            else add_noise();
            if (phase_no == 1) begin
                // Sender pause until every expected event has come.
                wait (byte_q.size() < 40);
                hold_tx = 1'b1;
                wait (!s_axis_tvalid && event_q.size() == 0);
                hold_tx = 1'b0;
            end
            wait_drained();
        end
        write_mask(apev2_pkg::HDR_MASK_RESET);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && event_q.size() == 0) begin
            $display("apev2_tag_stream_parser_unit verification clean");
        end else begin
            $display("apev2_tag_stream_parser_unit verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("apev2_tag_stream_parser_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/apev2_pkg.sv
hdl/apev2_front.sv
hdl/apev2_queue.sv
hdl/apev2_back.sv
hdl/apev2_tag_stream_parser_unit.sv
tb/tb_top.sv
